// File: sv/aes_pkg.sv
package aes_pkg;

    localparam int ROUNDS    = 10;
    localparam int BLK_W     = 128;
    localparam int CFG_IDX_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd1;

    typedef enum logic
    {
        OP_ENC = 1'b0,
        OP_DEC = 1'b1
    } op_t;

    // one round key per round, round 0 at index 0
    typedef logic [ROUNDS:0][BLK_W-1:0] rk_set_t;

    typedef struct packed
    {
        op_t              op;
        logic             eob;
        logic [BLK_W-1:0] data;
    } item_t;

    // forward S-box, entry 0 in the top byte
    localparam logic [2047:0] SBOX_BITS = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    // inverse S-box, built from the forward one at elaboration
    function automatic logic [2047:0] build_inv_sbox();
        logic [2047:0] r;
        logic [7:0]    s;
        r = '0;
        for (int i = 0; i < 256; i++)
        begin
            s = SBOX_BITS[8*(255-i) +: 8];
            r[8*(255-int'(s)) +: 8] = 8'(i);
        end
        return r;
    endfunction

    localparam logic [2047:0] INV_SBOX_BITS = build_inv_sbox();

    function automatic logic [7:0] sub_fwd(input logic [7:0] b);
        return SBOX_BITS[{~b, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] sub_inv(input logic [7:0] b);
        return INV_SBOX_BITS[{~b, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gm9(input logic [7:0] a);
        return xt(xt(xt(a))) ^ a;
    endfunction

    function automatic logic [7:0] gm11(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(a) ^ a;
    endfunction

    function automatic logic [7:0] gm13(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
    endfunction

    function automatic logic [7:0] gm14(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24];
        a1 = w[23:16];
        a2 = w[15:8];
        a3 = w[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24];
        a1 = w[23:16];
        a2 = w[15:8];
        a3 = w[7:0];
        return {gm14(a0) ^ gm11(a1) ^ gm13(a2) ^ gm9(a3),
                gm9(a0) ^ gm14(a1) ^ gm11(a2) ^ gm13(a3),
                gm13(a0) ^ gm9(a1) ^ gm14(a2) ^ gm11(a3),
                gm11(a0) ^ gm13(a1) ^ gm9(a2) ^ gm14(a3)};
    endfunction

    // one cipher round; decrypt follows the equivalent inverse cipher
    function automatic logic [BLK_W-1:0] cipher_round(input logic [BLK_W-1:0] st,
                                                      input logic dec,
                                                      input logic last,
                                                      input logic [BLK_W-1:0] key);
        logic [BLK_W-1:0] res;
        logic [31:0]      w;
        logic [7:0]       bt;
        int               src;
        res = '0;
        for (int c = 0; c < 4; c++)
        begin
            w = '0;
            for (int r = 0; r < 4; r++)
            begin
                src = dec ? ((c - r) & 3) : ((c + r) & 3);
                bt  = st[127-32*src-8*r -: 8];
                bt  = dec ? sub_inv(bt) : sub_fwd(bt);
                w[31-8*r -: 8] = bt;
            end
            if (!last)
            begin
                w = dec ? inv_mix_col(w) : mix_col(w);
            end
            res[127-32*c -: 32] = w ^ key[127-32*c -: 32];
        end
        return res;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] rnd);
        logic [7:0] r;
        case (rnd)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // next 128-bit round key from the previous one
    function automatic logic [BLK_W-1:0] next_round_key(input logic [BLK_W-1:0] prev,
                                                        input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
        w0 = prev[127:96];
        w1 = prev[95:64];
        w2 = prev[63:32];
        w3 = prev[31:0];
        t  = {sub_fwd(w3[23:16]) ^ rc, sub_fwd(w3[15:8]), sub_fwd(w3[7:0]),
              sub_fwd(w3[31:24])};
        n0 = w0 ^ t;
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    function automatic logic [BLK_W-1:0] inv_mix_key(input logic [BLK_W-1:0] k);
        return {inv_mix_col(k[127:96]), inv_mix_col(k[95:64]),
                inv_mix_col(k[63:32]), inv_mix_col(k[31:0])};
    endfunction

endpackage

// File: sv/aes_keysched.sv
module aes_keysched
    import aes_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    output rk_set_t              enc_rk,
    output rk_set_t              dec_rk,
    output logic                 busy
);

    logic [63:0]      key_high_reg, key_low_reg;
    logic             busy_reg;
    logic [3:0]       cnt_reg;
    logic [BLK_W-1:0] cur_reg;
    rk_set_t          enc_rk_reg, dec_rk_reg;
    logic [BLK_W-1:0] nxt_key;
    logic [3:0]       dec_idx;

    assign nxt_key = next_round_key(cur_reg, rcon(cnt_reg));
    assign dec_idx = 4'(ROUNDS) - cnt_reg;

    // key halves and expansion sequencer, one round per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            busy_reg     <= 1'b1;
            cnt_reg      <= '0;
        end
        else if (cfg_valid && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW))
        begin
            if (cfg_index == REG_KEY_HIGH)
            begin
                key_high_reg <= cfg_data;
            end
            else
            begin
                key_low_reg <= cfg_data;
            end
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 4'(ROUNDS))
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 4'd1;
        end
    end

    // round key storage
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (cnt_reg == 4'd0)
            begin
                cur_reg                <= {key_high_reg, key_low_reg};
                enc_rk_reg[0]          <= {key_high_reg, key_low_reg};
                dec_rk_reg[ROUNDS]     <= {key_high_reg, key_low_reg};
            end
            else
            begin
                cur_reg              <= nxt_key;
                enc_rk_reg[cnt_reg]  <= nxt_key;
                dec_rk_reg[dec_idx]  <= (cnt_reg == 4'(ROUNDS)) ? nxt_key
                                                                : inv_mix_key(nxt_key);
            end
        end
    end

    assign enc_rk = enc_rk_reg;
    assign dec_rk = dec_rk_reg;
    assign busy   = busy_reg;

endmodule

// File: sv/aes_front.sv
module aes_front
    import aes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        busy,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [63:0] block_hi,
    input  logic [63:0] block_lo,
    input  logic        end_of_buffer,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    item_t      in_item;

    assign in_stall = busy || (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;

    // classify the beat by operation and pack its end-of-buffer flag and data
    always_comb
    begin
        in_item.op   = operation ? OP_DEC : OP_ENC;
        in_item.eob  = end_of_buffer;
        in_item.data = {block_hi, block_lo};
    end

    // two-entry queue toward the round pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];

endmodule

// File: sv/aes_back.sv
module aes_back
    import aes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rk_set_t     enc_rk,
    input  rk_set_t     dec_rk,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_hi,
    output logic [63:0] result_lo,
    output logic        end_of_buffer_out
);

    logic [BLK_W-1:0] st_reg  [ROUNDS+1];
    op_t              op_reg  [ROUNDS+1];
    logic             eob_reg [ROUNDS+1];
    logic [ROUNDS:0]  v_reg;
    logic             adv;

    // whole pipeline holds while the last stage waits
    assign adv   = !(v_reg[ROUNDS] && out_stall);
    assign q_pop = adv && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[ROUNDS-1:0], q_valid};
        end
    end

    // initial key add
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0]  <= q_item.data ^ ((q_item.op == OP_DEC) ? dec_rk[0] : enc_rk[0]);
            op_reg[0]  <= q_item.op;
            eob_reg[0] <= q_item.eob;
        end
    end

    // one round per stage
    for (genvar r = 1; r <= ROUNDS; r++)
    begin : g_round
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[r]  <= cipher_round(st_reg[r-1], op_reg[r-1] == OP_DEC,
                                           r == ROUNDS,
                                           (op_reg[r-1] == OP_DEC) ? dec_rk[r] : enc_rk[r]);
                op_reg[r]  <= op_reg[r-1];
                eob_reg[r] <= eob_reg[r-1];
            end
        end
    end

    assign out_valid         = v_reg[ROUNDS];
    assign result_hi         = st_reg[ROUNDS][127:64];
    assign result_lo         = st_reg[ROUNDS][63:0];
    assign end_of_buffer_out = eob_reg[ROUNDS];

endmodule

// File: sv/aes128_block_cipher.sv
// AES-128 ECB engine. Takes one 128-bit block per cycle while in_stall is low (encrypt or
// decrypt chosen per beat) and returns one result per block in order, passing through the
// two-entry input queue, the initial key add, then one pipeline stage per round.
// The key is written as two 64-bit halves; after reset and after each key write the
// schedule is rebuilt one round per cycle, during which in_stall is high.
// The config port is always ready; key writes belong in idle periods.
module aes128_block_cipher
    import aes_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 operation,
    input  logic [63:0]          block_hi,
    input  logic [63:0]          block_lo,
    input  logic                 end_of_buffer,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [63:0]          result_hi,
    output logic [63:0]          result_lo,
    output logic                 end_of_buffer_out
);

    rk_set_t enc_rk, dec_rk;
    logic    busy;
    logic    q_valid, q_pop;
    item_t   q_item;

    assign cfg_ready = 1'b1;

    aes_keysched u_keysched
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .enc_rk    (enc_rk),
        .dec_rk    (dec_rk),
        .busy      (busy)
    );

    aes_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .busy          (busy),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .block_hi      (block_hi),
        .block_lo      (block_lo),
        .end_of_buffer (end_of_buffer),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    aes_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .enc_rk            (enc_rk),
        .dec_rk            (dec_rk),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_pop             (q_pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .result_hi         (result_hi),
        .result_lo         (result_lo),
        .end_of_buffer_out (end_of_buffer_out)
    );

endmodule
